>>> design/ptb_pkg.sv
package ptb_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int MAX_RESULTS = 16;

	localparam int ACTION_W = 2;
	localparam int ID_W     = 4;
	localparam int IVL_W    = 15;
	localparam int TIME_W   = 16;

	localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     timer_id;
		logic [IVL_W-1:0]    interval;
		logic [TIME_W-1:0]   now;
	} req_t;

	typedef struct packed {
		logic            fired;
		logic [ID_W-1:0] fired_id;
		logic            running;
		logic            last;
	} res_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_START,
		OP_STOP,
		OP_QUERY,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [IVL_W-1:0] interval;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} back_state_t;

endpackage

>>> design/ptb_front.sv
module ptb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  ptb_pkg::req_t cmd,
	output logic          cmd_valid,
	output ptb_pkg::cmd_t cmd_out,
	input  logic          cmd_pop
);
	import ptb_pkg::*;

	// Two-entry queue of decoded commands.
	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		dec.idx      = IDX_W'(cmd.timer_id);
		dec.interval = cmd.interval;
		dec.now      = cmd.now;
		if (cmd.action == ACT_TICK) begin
			dec.op = OP_TICK;
		end else if (32'(cmd.timer_id) >= NUM_TIMERS) begin
			dec.op = OP_BAD;
		end else begin
			case (cmd.action)
				ACT_START: dec.op = OP_START;
				ACT_STOP:  dec.op = OP_STOP;
				ACT_QUERY: dec.op = OP_QUERY;
				default:   dec.op = OP_BAD;
			endcase
		end
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_out   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

endmodule

>>> design/ptb_res_q.sv
module ptb_res_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  ptb_pkg::res_t res_item,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output ptb_pkg::res_t result
);
	import ptb_pkg::*;

	// Four-entry result queue.
	res_t       mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (count_q == 3'd4);
	assign empty    = (count_q == 3'd0);
	assign result   = mem_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= res_item;
		end
	end

endmodule

>>> design/ptb_back.sv
module ptb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  ptb_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output ptb_pkg::res_t res_item
);
	import ptb_pkg::*;

	back_state_t      state_q;
	back_state_t      state_d;
	logic [IDX_W-1:0] idx_q;
	logic [TIME_W-1:0] now_q;
	logic [FIRE_W-1:0] fires_q;
	logic             hold_v_q;
	logic [IDX_W-1:0] hold_id_q;

	logic [NUM_TIMERS-1:0] armed_q;
	logic [IVL_W-1:0]      period_q   [NUM_TIMERS];
	logic [TIME_W-1:0]     deadline_q [NUM_TIMERS];

	logic [IDX_W-1:0]  rd_idx;
	logic              rd_armed;
	logic [TIME_W-1:0] rd_dl;
	logic [IVL_W-1:0]  rd_per;
	logic [TIME_W-1:0] late;
	logic [TIME_W-1:0] early;
	logic              due;
	logic              scan_fire;
	logic              scan_step;
	logic              tick_start;
	logic              wr_start;
	logic              wr_stop;
	logic              flush_done;

	assign rd_idx   = (state_q == ST_SCAN) ? idx_q : cmd.idx;
	assign rd_armed = armed_q[rd_idx];
	assign rd_dl    = deadline_q[rd_idx];
	assign rd_per   = period_q[rd_idx];
	assign late     = now_q - rd_dl;
	assign early    = rd_dl - now_q;
	// Due if armed, under the fire cap, and no later than it is early.
	assign due      = rd_armed && (late <= early) && (fires_q < FIRE_W'(MAX_RESULTS));

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_item   = '0;
		scan_fire  = 1'b0;
		scan_step  = 1'b0;
		tick_start = 1'b0;
		wr_start   = 1'b0;
		wr_stop    = 1'b0;
		flush_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_TICK) begin
						cmd_pop    = 1'b1;
						tick_start = 1'b1;
						state_d    = ST_SCAN;
					end else if (!res_full) begin
						cmd_pop       = 1'b1;
						res_push      = 1'b1;
						res_item.last = 1'b1;
						case (cmd.op)
							OP_START: begin
								res_item.running = 1'b1;
								wr_start         = !rd_armed;
							end
							OP_STOP: begin
								res_item.running = 1'b0;
								wr_stop          = 1'b1;
							end
							OP_QUERY: res_item.running = rd_armed;
							default:  res_item.running = 1'b0;
						endcase
					end
				end
			end
			ST_SCAN: begin
				// A new fire releases the one held before it, which is not the last.
				if (!(due && hold_v_q && res_full)) begin
					scan_step = 1'b1;
					scan_fire = due;
					if (due && hold_v_q) begin
						res_push          = 1'b1;
						res_item.fired    = 1'b1;
						res_item.fired_id = ID_W'(hold_id_q);
						res_item.running  = 1'b1;
					end
					if (32'(idx_q) == NUM_TIMERS - 1) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (!res_full) begin
					res_push          = 1'b1;
					res_item.fired    = 1'b1;
					res_item.fired_id = ID_W'(hold_id_q);
					res_item.running  = 1'b1;
					res_item.last     = 1'b1;
					flush_done        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			fires_q  <= '0;
			hold_v_q <= 1'b0;
			armed_q  <= '0;
		end else begin
			state_q <= state_d;
			if (tick_start) begin
				idx_q    <= '0;
				fires_q  <= '0;
				hold_v_q <= 1'b0;
			end
			if (scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (scan_fire) begin
				fires_q  <= fires_q + FIRE_W'(1);
				hold_v_q <= 1'b1;
			end
			if (flush_done) begin
				hold_v_q <= 1'b0;
			end
			if (wr_start) begin
				armed_q[rd_idx] <= 1'b1;
			end
			if (wr_stop) begin
				armed_q[rd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_start) begin
			now_q <= cmd.now;
		end
		if (scan_fire) begin
			hold_id_q          <= idx_q;
			deadline_q[rd_idx] <= now_q + TIME_W'(rd_per);
		end
		if (wr_start) begin
			period_q[rd_idx]   <= cmd.interval;
			deadline_q[rd_idx] <= cmd.now + TIME_W'(cmd.interval);
		end
	end

endmodule

>>> design/periodic_timer_bank.sv
// Periodic timer bank: sixteen timers on a wrapping 16-bit millisecond time.
// Start, stop and query requests each give a single result, which the back end
// pushes into the result queue as it takes the request from the front queue.
// A tick request holds the back end in its scan and flush states; the scanner reads
// one stored timer per cycle, stalling only on a full result queue; fires stream out.
// Reset (arst_n low, asynchronous) disarms every timer and empties both queues.
module periodic_timer_bank (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  ptb_pkg::req_t cmd,
	output logic          empty,
	input  logic          pop,
	output ptb_pkg::res_t result
);
	import ptb_pkg::*;

	// Front end: the request queue decodes the action and checks the timer
	// index, so the back end only sees one of a few operation codes.
	logic cmd_valid;
	cmd_t cmd_head;
	logic cmd_pop;

	// Back end to result queue.
	logic res_push;
	res_t res_item;
	logic res_full;

	ptb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_out   (cmd_head),
		.cmd_pop   (cmd_pop)
	);

	// The back end holds the timer store and the tick scanner. During a scan
	// the most recent fire is held back until the scanner knows whether
	// another fire follows, which is how the last flag is set on the final one.
	ptb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// The result queue lets the scanner keep running while results wait to be
	// taken; the scanner stalls only when the queue is full.
	ptb_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// The back end never pushes into a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(res_push && res_full))
		else $error("result pushed into full queue");

	// A fire result always reports a running timer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.fired) |-> result.running)
		else $error("fire result without running flag");

	// A non-fire result answers a single request: it is the last and carries id zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.fired) |-> (result.last && result.fired_id == '0))
		else $error("malformed answer to start, stop or query");

	// A request is only taken from the front queue when one is there.
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("pop from empty request queue");

endmodule
